// ===== rtl/mbtcp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbtcp_pkg
// Shared types and constants of the Modbus/TCP slave responder.
// ----------------------------------------------------------------------------
package mbtcp_pkg;

	// request framing
	localparam int          HEAD_BYTES = 12;
	localparam int          CNT_W      = 9;
	localparam logic [8:0]  CNT_MAX    = 9'd511;
	localparam logic [8:0]  HDR_BYTES  = 9'd6;
	localparam logic [8:0]  FRAME_MAX  = 9'd259;   // 6 header bytes + largest length
	localparam logic [15:0] PLEN_MIN   = 16'd2;
	localparam logic [15:0] PLEN_MAX   = 16'd253;
	localparam logic [15:0] PLEN_FIXED = 16'd6;    // 12-byte request

	// function codes
	localparam logic [7:0] FN_READ_COILS    = 8'd1;
	localparam logic [7:0] FN_READ_DISCRETE = 8'd2;
	localparam logic [7:0] FN_READ_HOLDING  = 8'd3;
	localparam logic [7:0] FN_READ_INPUTS   = 8'd4;
	localparam logic [7:0] FN_WRITE_COIL    = 8'd5;
	localparam logic [7:0] FN_WRITE_REG     = 8'd6;
	localparam logic [7:0] FN_WRITE_COILS   = 8'd15;
	localparam logic [7:0] FN_WRITE_REGS    = 8'd16;
	localparam logic [7:0] FN_REPORT_ID     = 8'd17;

	// exception codes
	localparam logic [7:0] EXC_ILLEGAL_FN    = 8'd1;
	localparam logic [7:0] EXC_ILLEGAL_VALUE = 8'd3;
	localparam logic [7:0] EXC_FLAG          = 8'h80;

	// quantity limits
	localparam logic [15:0] QTY_BITS_MAX   = 16'd2000;
	localparam logic [15:0] QTY_REGS_MAX   = 16'd125;
	localparam logic [15:0] QTY_WCOILS_MAX = 16'd1968;
	localparam logic [15:0] QTY_WREGS_MAX  = 16'd123;

	// configuration register indexes
	localparam int         CFG_IDX_W     = 3;
	localparam logic [2:0] REG_ENABLE    = 3'd0;
	localparam logic [2:0] REG_ID_FIRST  = 3'd1;
	localparam logic [2:0] REG_ID_SECOND = 3'd2;
	localparam logic [2:0] REG_ID_LENGTH = 3'd3;

	// descriptor queue
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	typedef logic [2:0] kind_t;
	localparam kind_t KIND_BITS  = 3'd0;
	localparam kind_t KIND_REGS  = 3'd1;
	localparam kind_t KIND_ECHO  = 3'd2;
	localparam kind_t KIND_IDENT = 3'd3;
	localparam kind_t KIND_EXC   = 3'd4;

	// one classified request, ready for the response builder
	typedef struct packed {
		logic [31:0] mbap;      // request bytes 0..3
		logic [7:0]  unit;
		logic [7:0]  fn;
		logic [31:0] body;      // request bytes 8..11
		kind_t       kind;
		logic [7:0]  exc_code;
		logic [8:0]  total;     // response length in bytes
	} desc_t;

endpackage

// ===== rtl/mbtcp_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbtcp_queue
// Short FIFO of request descriptors between the framer and the builder.
// ----------------------------------------------------------------------------
module mbtcp_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  mbtcp_pkg::desc_t push_desc,
	input  logic             pop,
	output mbtcp_pkg::desc_t pop_desc,
	output logic             not_empty,
	output logic             full
);

	mbtcp_pkg::desc_t                  mem_q [mbtcp_pkg::Q_DEPTH];
	logic [mbtcp_pkg::Q_PTR_W-1:0]     wr_q;
	logic [mbtcp_pkg::Q_PTR_W-1:0]     rd_q;
	logic [mbtcp_pkg::Q_CNT_W-1:0]     count_q;

	localparam logic [mbtcp_pkg::Q_PTR_W-1:0] LAST_PTR =
		mbtcp_pkg::Q_PTR_W'(mbtcp_pkg::Q_DEPTH - 1);
	localparam logic [mbtcp_pkg::Q_CNT_W-1:0] FULL_CNT =
		mbtcp_pkg::Q_CNT_W'(mbtcp_pkg::Q_DEPTH);

	assign not_empty = (count_q != '0);
	assign full      = (count_q == FULL_CNT);
	assign pop_desc  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == LAST_PTR) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == LAST_PTR) ? '0 : rd_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("descriptor pushed into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("descriptor popped from empty queue");

endmodule

// ===== rtl/mbtcp_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbtcp_front
// Frames request bytes, checks the header and classifies finished requests.
// ----------------------------------------------------------------------------
module mbtcp_front #(
	parameter int ID_MAX_BYTES = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic             op,
	input  logic [7:0]       rx_byte,
	input  logic             enable,
	input  logic [4:0]       id_length,
	output logic             push,
	output mbtcp_pkg::desc_t desc
);

	localparam logic [4:0] ID_CAP = 5'(ID_MAX_BYTES);

	logic [7:0]                  head_q [mbtcp_pkg::HEAD_BYTES];
	logic [mbtcp_pkg::CNT_W-1:0] count_q;

	logic [7:0]                  head_n [mbtcp_pkg::HEAD_BYTES];
	logic [mbtcp_pkg::CNT_W-1:0] count_n;
	logic [mbtcp_pkg::CNT_W-1:0] req_end;
	logic [15:0]                 proto;
	logic [15:0]                 plen;
	logic [15:0]                 qty;
	logic [7:0]                  fn;
	logic                        hdr_seen;
	logic                        hdr_bad;
	logic                        done;
	logic                        act;
	logic                        clear;
	logic                        len_ok;
	logic [16:0]                 bits_sum;
	logic [7:0]                  bits_nb;
	logic [7:0]                  regs_nb;
	logic [4:0]                  id_n;

	// frame view including the byte arriving now
	always_comb begin
		for (int i = 0; i < mbtcp_pkg::HEAD_BYTES; i++) begin
			head_n[i] = (count_q == mbtcp_pkg::CNT_W'(i)) ? rx_byte : head_q[i];
		end
	end

	assign count_n  = (count_q == mbtcp_pkg::CNT_MAX) ? count_q : count_q + 9'd1;
	assign proto    = {head_n[2], head_n[3]};
	assign plen     = {head_n[4], head_n[5]};
	assign hdr_seen = (count_n >= mbtcp_pkg::HDR_BYTES);
	assign hdr_bad  = (proto != 16'd0) || (plen < mbtcp_pkg::PLEN_MIN) ||
	                  (plen > mbtcp_pkg::PLEN_MAX);
	assign req_end  = mbtcp_pkg::HDR_BYTES + {1'b0, plen[7:0]};
	assign done     = hdr_seen && !hdr_bad && (count_n >= req_end);
	assign act      = accept && enable;
	assign clear    = act && (op || (hdr_seen && (hdr_bad || done)));
	assign push     = act && !op && done;

	// classification
	assign fn       = head_n[7];
	assign qty      = {head_n[10], head_n[11]};
	assign len_ok   = (plen == mbtcp_pkg::PLEN_FIXED);
	assign bits_sum = {1'b0, qty} + 17'd7;
	assign bits_nb  = bits_sum[10:3];
	assign regs_nb  = {qty[6:0], 1'b0};
	assign id_n     = (id_length > ID_CAP) ? ID_CAP : id_length;

	always_comb begin
		desc.mbap     = {head_n[0], head_n[1], head_n[2], head_n[3]};
		desc.unit     = head_n[6];
		desc.fn       = fn;
		desc.body     = {head_n[8], head_n[9], head_n[10], head_n[11]};
		desc.kind     = mbtcp_pkg::KIND_EXC;
		desc.exc_code = mbtcp_pkg::EXC_ILLEGAL_VALUE;
		desc.total    = 9'd9;
		unique case (fn)
			mbtcp_pkg::FN_READ_COILS, mbtcp_pkg::FN_READ_DISCRETE: begin
				if (len_ok && qty != 16'd0 && qty <= mbtcp_pkg::QTY_BITS_MAX) begin
					desc.kind  = mbtcp_pkg::KIND_BITS;
					desc.total = 9'd9 + {1'b0, bits_nb};
				end
			end
			mbtcp_pkg::FN_READ_HOLDING, mbtcp_pkg::FN_READ_INPUTS: begin
				if (len_ok && qty != 16'd0 && qty <= mbtcp_pkg::QTY_REGS_MAX) begin
					desc.kind  = mbtcp_pkg::KIND_REGS;
					desc.total = 9'd9 + {1'b0, regs_nb};
				end
			end
			mbtcp_pkg::FN_WRITE_COIL, mbtcp_pkg::FN_WRITE_REG: begin
				if (len_ok) begin
					desc.kind  = mbtcp_pkg::KIND_ECHO;
					desc.total = 9'd12;
				end
			end
			mbtcp_pkg::FN_WRITE_COILS: begin
				if (qty != 16'd0 && qty <= mbtcp_pkg::QTY_WCOILS_MAX) begin
					desc.kind  = mbtcp_pkg::KIND_ECHO;
					desc.total = 9'd12;
				end
			end
			mbtcp_pkg::FN_WRITE_REGS: begin
				if (qty != 16'd0 && qty <= mbtcp_pkg::QTY_WREGS_MAX) begin
					desc.kind  = mbtcp_pkg::KIND_ECHO;
					desc.total = 9'd12;
				end
			end
			mbtcp_pkg::FN_REPORT_ID: begin
				desc.kind  = mbtcp_pkg::KIND_IDENT;
				desc.total = 9'd9 + {4'd0, id_n};
			end
			default: begin
				desc.exc_code = mbtcp_pkg::EXC_ILLEGAL_FN;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < mbtcp_pkg::HEAD_BYTES; i++) begin
				head_q[i] <= 8'd0;
			end
			count_q <= '0;
		end else if (clear) begin
			for (int i = 0; i < mbtcp_pkg::HEAD_BYTES; i++) begin
				head_q[i] <= 8'd0;
			end
			count_q <= '0;
		end else if (act) begin
			if (count_q < mbtcp_pkg::CNT_W'(mbtcp_pkg::HEAD_BYTES)) begin
				head_q[count_q[3:0]] <= rx_byte;
			end
			count_q <= count_n;
		end
	end

	// a frame always ends or is dropped before the longest legal length
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q < mbtcp_pkg::FRAME_MAX)
		else $error("frame byte count past longest request");

endmodule

// ===== rtl/mbtcp_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbtcp_back
// Builds the response of one descriptor, eight bytes per output word.
// ----------------------------------------------------------------------------
module mbtcp_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  mbtcp_pkg::desc_t q_desc,
	output logic             q_pop,
	input  logic [63:0]      id_text_first,
	input  logic [63:0]      id_text_second,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [63:0]      out_bytes,
	output logic [3:0]       valid_bytes,
	output logic             last
);

	mbtcp_pkg::desc_t cur_q;
	logic             busy_q;
	logic [5:0]       k_q;
	logic             out_valid_q;
	logic [63:0]      out_bytes_q;
	logic [3:0]       valid_bytes_q;
	logic             last_q;

	logic             adv;
	logic [8:0]       base;
	logic [8:0]       cnt;
	logic             word_last;
	logic [63:0]      word;

	// response byte at position p
	function automatic logic [7:0] resp_byte(input mbtcp_pkg::desc_t d,
	                                         input logic [8:0] p,
	                                         input logic [63:0] idf,
	                                         input logic [63:0] ids);
		logic [8:0]  o;
		logic [15:0] v;
		logic [63:0] w;
		logic [7:0]  b;
		o = p - 9'd9;
		v = d.body[31:16] + {8'd0, o[8:1]};
		w = o[3] ? ids : idf;
		b = 8'd0;
		unique case (p)
			9'd0: b = d.mbap[31:24];
			9'd1: b = d.mbap[23:16];
			9'd2: b = d.mbap[15:8];
			9'd3: b = d.mbap[7:0];
			9'd4: b = 8'd0;
			9'd5: b = 8'(d.total - 9'd6);
			9'd6: b = d.unit;
			9'd7: b = (d.kind == mbtcp_pkg::KIND_EXC) ? (d.fn | mbtcp_pkg::EXC_FLAG) : d.fn;
			9'd8: begin
				if (d.kind == mbtcp_pkg::KIND_EXC) begin
					b = d.exc_code;
				end else if (d.kind == mbtcp_pkg::KIND_ECHO) begin
					b = d.body[31:24];
				end else begin
					b = 8'(d.total - 9'd9);
				end
			end
			default: begin
				unique case (d.kind)
					mbtcp_pkg::KIND_REGS:  b = o[0] ? v[7:0] : v[15:8];
					mbtcp_pkg::KIND_IDENT: b = 8'(w >> {3'd7 - o[2:0], 3'b000});
					mbtcp_pkg::KIND_ECHO: begin
						unique case (o[1:0])
							2'd0:    b = d.body[23:16];
							2'd1:    b = d.body[15:8];
							2'd2:    b = d.body[7:0];
							default: b = 8'd0;
						endcase
					end
					default: b = 8'd0;
				endcase
			end
		endcase
		return b;
	endfunction

	assign q_pop     = !busy_q && q_valid;
	assign adv       = busy_q && (!out_valid_q || !out_stall);
	assign base      = {k_q, 3'b000};
	assign cnt       = cur_q.total - base;
	assign word_last = (cnt <= 9'd8);

	always_comb begin
		for (int j = 0; j < 8; j++) begin
			word[63 - 8*j -: 8] = ((base + 9'(j)) < cur_q.total) ?
				resp_byte(cur_q, base + 9'(j), id_text_first, id_text_second) : 8'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_desc;
		end
		if (adv) begin
			out_bytes_q   <= word;
			valid_bytes_q <= word_last ? cnt[3:0] : 4'd8;
			last_q        <= word_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				busy_q <= 1'b1;
				k_q    <= '0;
			end else if (adv) begin
				if (word_last) begin
					busy_q <= 1'b0;
				end else begin
					k_q <= k_q + 6'd1;
				end
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign out_bytes   = out_bytes_q;
	assign valid_bytes = valid_bytes_q;
	assign last        = last_q;

	a_word_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (base < cur_q.total))
		else $error("word index ran past response length");

	a_done_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && word_last) |=> (!busy_q && out_valid_q && last_q))
		else $error("builder still busy after final word");

	a_count_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (valid_bytes_q != 4'd0 && valid_bytes_q <= 4'd8))
		else $error("output word byte count out of range");

endmodule

// ===== rtl/modbus_tcp_slave_responder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modbus_tcp_slave_responder_core
// Frames Modbus/TCP requests from a byte stream and returns simulated
// responses as 8-byte words.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake              Payload
// request   in         in_valid / in_stall    op, rx_byte
// response  out        out_valid / out_stall  out_bytes, valid_bytes, last
// config    in         cfg_we                 cfg_index, cfg_data
//
// Flow: the framer takes one request byte per cycle while the descriptor
//   queue has room. A response of N words (2..33) leaves at one word per
//   cycle while out_stall is low; its first word is registered in the queue,
//   then in the descriptor register, then in the output register, and the
//   builder goes idle between consecutive responses to load the next one.
// Reset: arst_n clears the frame buffer, byte count, queue, builder state and
//   configuration; no clearing pass is needed afterwards.
// Stalls: in_stall is high while the two-entry queue is full; out_stall holds
//   the output register and pauses the builder without blocking the framer.
//
module modbus_tcp_slave_responder_core #(
	parameter int ID_MAX_BYTES = 16     // cap on identifier length, 8..16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// request bytes
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            op,
	input  logic [7:0]                      rx_byte,
	// response words
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [63:0]                     out_bytes,
	output logic [3:0]                      valid_bytes,
	output logic                            last,
	// register writes
	input  logic                            cfg_we,
	input  logic [mbtcp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]                     cfg_data
);

	// configuration registers
	logic        enable_q;
	logic [63:0] id_first_q;
	logic [63:0] id_second_q;
	logic [4:0]  id_length_q;

	// front <-> queue <-> back
	logic             accept;
	logic             q_push;
	logic             q_pop;
	logic             q_not_empty;
	logic             q_full;
	mbtcp_pkg::desc_t front_desc;
	mbtcp_pkg::desc_t back_desc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q    <= 1'b0;
			id_first_q  <= '0;
			id_second_q <= '0;
			id_length_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mbtcp_pkg::REG_ENABLE:    enable_q    <= cfg_data[0];
				mbtcp_pkg::REG_ID_FIRST:  id_first_q  <= cfg_data;
				mbtcp_pkg::REG_ID_SECOND: id_second_q <= cfg_data;
				mbtcp_pkg::REG_ID_LENGTH: id_length_q <= cfg_data[4:0];
				default: ;   // unmapped index: ignored
			endcase
		end
	end

	// Hold off new bytes whenever the queue cannot take a finished request.
	assign in_stall = q_full;
	assign accept   = in_valid && !in_stall;

	// front: framing, header check, classification
	mbtcp_front #(
		.ID_MAX_BYTES (ID_MAX_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.op        (op),
		.rx_byte   (rx_byte),
		.enable    (enable_q),
		.id_length (id_length_q),
		.push      (q_push),
		.desc      (front_desc)
	);

	// decoupling queue
	mbtcp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_desc (front_desc),
		.pop       (q_pop),
		.pop_desc  (back_desc),
		.not_empty (q_not_empty),
		.full      (q_full)
	);

	// back: response word generation
	mbtcp_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_valid        (q_not_empty),
		.q_desc         (back_desc),
		.q_pop          (q_pop),
		.id_text_first  (id_first_q),
		.id_text_second (id_second_q),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_bytes      (out_bytes),
		.valid_bytes    (valid_bytes),
		.last           (last)
	);

endmodule
